/* sv/kvcl_pkg.sv */
// Shared types, constants and character-class functions for the key=value lexer.
`timescale 1ns / 1ps
`default_nettype none

package kvcl_pkg;

  localparam int LINE_BITS        = 16;
  localparam int LINE_NUMBER_BITS = 16;

  localparam logic [7:0] CHAR_HASH      = 8'h23;
  localparam logic [7:0] CHAR_EQUALS    = 8'h3D;
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_UNDERLINE = 8'h5F;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_COMMENT  = 3'd1,
    ST_KEY      = 3'd2,
    ST_SEEK_EQ  = 3'd3,
    ST_SEEK_VAL = 3'd4,
    ST_BARE     = 3'd5,
    ST_QUOTED   = 3'd6,
    ST_SEEK_EOL = 3'd7
  } lex_state_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_CHAR    = 3'd1,
    ERR_COMMENT = 3'd2,
    ERR_STRING  = 3'd3,
    ERR_UNTERM  = 3'd4
  } lex_error_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c >= 8'h21) && (c <= 8'h7E) && !is_alnum(c);
  endfunction

  function automatic logic is_key_body(input logic [7:0] c);
    return is_alnum(c) || (c == CHAR_UNDERLINE);
  endfunction

  function automatic logic is_value_body(input logic [7:0] c);
    return is_alnum(c) || is_punct(c);
  endfunction

endpackage

`default_nettype wire

/* sv/key_value_config_lexer_core.sv */
// Key=value configuration lexer: one text byte in, one classified byte out.
`timescale 1ns / 1ps
`default_nettype none

// Streaming lexer for key=value configuration text. Each accepted transaction
// carries one byte (data_byte) and an end_of_file mark; each yields exactly one
// result transaction that echoes the byte and flags it as key start, key
// character, value start, value character or pair completion, together with
// the error code, the current line number and, on an error-free last byte,
// file_done. The block takes one transaction per cycle while the result
// channel does not stall: a byte is captured in an input register,
// classified and stepped through the eight-state lexer in a single pass of
// logic, and written to a result register, from which it leaves. While a
// result is held off, the input register holds and the input channel stalls.
// Errors are sticky until the end-of-file transaction, which returns the
// lexer, line count and error to their reset values. The line count starts
// at 1 and saturates.
module key_value_config_lexer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_file,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       char_out,
  output logic             key_start,
  output logic             key_char,
  output logic             value_start,
  output logic             value_char,
  output logic             pair_done,
  output logic [2:0]       error_code,
  output logic [kvcl_pkg::LINE_NUMBER_BITS-1:0] line_number,
  output logic             file_done
);

  import kvcl_pkg::*;

  // Input register
  logic       in_reg_valid;
  logic [7:0] in_reg_byte;
  logic       in_reg_eof;

  // Lexer state
  lex_state_t           lex_state, lex_state_next;
  logic [LINE_BITS-1:0] line_count, line_count_next;
  lex_error_t           held_error, held_error_next;

  // Per-byte outcome
  logic       ks, kc, vs, vc, pd, done;
  lex_error_t err_out;
  logic [LINE_BITS-1:0] line_out;
  logic [31:0]          line_wide;

  logic out_advance;
  logic step;

  // The result register may load when empty or when its contents leave now.
  assign out_advance = !out_valid || !out_stall;
  // The input register holds only while its transaction cannot move on.
  assign in_stall    = in_reg_valid && !out_advance;
  assign step        = in_reg_valid && out_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_reg_byte <= data_byte;
      in_reg_eof  <= end_of_file;
    end
  end

  // State registers: advance only when a byte is stepped through the lexer.
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_state  <= ST_IDLE;
      line_count <= LINE_BITS'(1);
      held_error <= ERR_NONE;
    end else if (step) begin
      lex_state  <= lex_state_next;
      line_count <= line_count_next;
      held_error <= held_error_next;
    end
  end

  // Next state and per-byte flags
  always_comb begin
    lex_state_t           s;
    lex_error_t           err;
    lex_error_t           held;
    lex_state_t           st_after;
    logic [LINE_BITS-1:0] lc;
    logic [7:0]           c;

    c    = in_reg_byte;
    s    = lex_state;
    err  = ERR_NONE;
    held = held_error;
    lc   = line_count;
    st_after = lex_state;
    ks = 1'b0;
    kc = 1'b0;
    vs = 1'b0;
    vc = 1'b0;
    pd = 1'b0;

    if (held_error == ERR_NONE) begin
      // Count newlines before the lexer step; saturate at the top.
      if (c == CHAR_NEWLINE && lc != '1) begin
        lc = lc + LINE_BITS'(1);
      end

      unique case (lex_state)
        ST_IDLE: begin
          if (is_space(c)) begin
          end else if (c == CHAR_HASH) begin
            s = ST_COMMENT;
          end else if (is_alpha(c)) begin
            s  = ST_KEY;
            ks = 1'b1;
            kc = 1'b1;
          end else begin
            err = ERR_CHAR;
          end
        end
        ST_COMMENT: begin
          if (c == CHAR_NEWLINE) s = ST_IDLE;
        end
        ST_KEY: begin
          if (is_key_body(c))          kc = 1'b1;
          else if (is_space(c))        s = ST_SEEK_EQ;
          else if (c == CHAR_EQUALS)   s = ST_SEEK_VAL;
          else                         err = ERR_CHAR;
        end
        ST_SEEK_EQ: begin
          if (is_space(c)) begin
          end else if (c == CHAR_EQUALS) begin
            s = ST_SEEK_VAL;
          end else begin
            err = ERR_CHAR;
          end
        end
        ST_SEEK_VAL: begin
          if (is_space(c)) begin
          end else if (c == CHAR_QUOTE) begin
            s  = ST_QUOTED;
            vs = 1'b1;
          end else if (is_value_body(c)) begin
            s  = ST_BARE;
            vs = 1'b1;
            vc = 1'b1;
          end else begin
            err = ERR_CHAR;
          end
        end
        ST_BARE: begin
          if (c == CHAR_HASH) begin
            err = ERR_COMMENT;
          end else if (is_space(c)) begin
            // a newline here still needs another one to reach idle
            s  = ST_SEEK_EOL;
            pd = 1'b1;
          end else if (is_value_body(c)) begin
            vc = 1'b1;
          end else begin
            err = ERR_CHAR;
          end
        end
        ST_QUOTED: begin
          if (c == CHAR_QUOTE) begin
            s  = ST_SEEK_EOL;
            pd = 1'b1;
          end else if (c == CHAR_NEWLINE || c == CHAR_BACKSLASH) begin
            err = ERR_STRING;
          end else begin
            vc = 1'b1;
          end
        end
        ST_SEEK_EOL: begin
          if (c == CHAR_NEWLINE)   s = ST_IDLE;
          else if (!is_space(c))   err = ERR_CHAR;
        end
        default: begin
          err = ERR_CHAR;
        end
      endcase

      // An error drops every flag and freezes the lexer state.
      if (err != ERR_NONE) begin
        ks = 1'b0;
        kc = 1'b0;
        vs = 1'b0;
        vc = 1'b0;
        pd = 1'b0;
        held = err;
      end else begin
        st_after = s;
      end
    end

    // Unterminated assignment is judged on the end-of-file byte.
    if (in_reg_eof && held == ERR_NONE && st_after != ST_IDLE) begin
      held = ERR_UNTERM;
    end

    err_out  = held;
    line_out = lc;
    done     = in_reg_eof && (held == ERR_NONE);

    if (in_reg_eof) begin
      lex_state_next  = ST_IDLE;
      line_count_next = LINE_BITS'(1);
      held_error_next = ERR_NONE;
    end else begin
      lex_state_next  = st_after;
      line_count_next = lc;
      held_error_next = held;
    end
  end

  assign line_wide = 32'(line_out);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      char_out    <= in_reg_byte;
      key_start   <= ks;
      key_char    <= kc;
      value_start <= vs;
      value_char  <= vc;
      pair_done   <= pd;
      error_code  <= err_out;
      line_number <= line_wide[LINE_NUMBER_BITS-1:0];
      file_done   <= done;
    end
  end

endmodule

`default_nettype wire
